@@ rtl/heightfield_max_binning_macros.svh @@
// ---------------------------------------------------------------------------
// heightfield_max_binning assertion macros
// Shared property templates for the height grid binning block.
// ---------------------------------------------------------------------------
`ifndef HEIGHTFIELD_MAX_BINNING_MACROS_SVH
`define HEIGHTFIELD_MAX_BINNING_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HMB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HMB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hmb_pkg.sv @@
// ---------------------------------------------------------------------------
// hmb_pkg
// Types, widths and codes shared by the height grid binning block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hmb_pkg;

	// default grid side length
	localparam int DEF_MAX_SIDE = 128;

	// field widths
	localparam int COORD_W   = 32;
	localparam int STEP_W    = 31;
	localparam int PTS_REG_W = 8;
	localparam int CELL_W    = 7;
	localparam int CFG_IDX_W = 3;

	// divider widths: quotient bits cover up to 2*256-1, enough to saturate
	localparam int QUO_W  = PTS_REG_W + 1;
	localparam int LAND_W = QUO_W - 1;
	localparam int NUM_W  = COORD_W + 3;
	localparam int DEN_W  = STEP_W + 2;
	localparam int DIV_W  = DEN_W + QUO_W - 1;
	localparam int CNT_W  = $clog2(QUO_W + 1);
	localparam int CMP_W  = 16;

	// item kinds
	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_VERTEX = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Z   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS_X = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS_Z = 3'd6;

	// input word
	typedef struct packed {
		logic [1:0]                kind;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [CELL_W-1:0]         cell_col;
		logic [CELL_W-1:0]         cell_row;
	} hmb_in_t;

	// result word
	typedef struct packed {
		logic signed [COORD_W-1:0] height;
		logic [CELL_W-1:0]         landed_col;
		logic [CELL_W-1:0]         landed_row;
		logic                      status;
	} hmb_out_t;

	// decoded configuration, steps already forced nonzero
	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_z;
		logic [STEP_W-1:0]         step_x;
		logic [STEP_W-1:0]         step_z;
		logic signed [COORD_W-1:0] floor_height;
	} hmb_cfg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_XGO,
		ST_XRUN,
		ST_ZGO,
		ST_ZRUN,
		ST_RD,
		ST_UPD
	} hmb_state_t;

endpackage

`default_nettype wire

@@ rtl/hmb_cfg.sv @@
// ---------------------------------------------------------------------------
// hmb_cfg
// Configuration register file with step and grid size sanitizing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmb_cfg import hmb_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata,
	output hmb_cfg_t             cfg,
	output logic [$clog2(MAX_SIDE):0] pts_x,
	output logic [$clog2(MAX_SIDE):0] pts_z
);

	localparam int PTS_W = $clog2(MAX_SIDE) + 1;

	logic signed [COORD_W-1:0] origin_x_q;
	logic signed [COORD_W-1:0] origin_z_q;
	logic [STEP_W-1:0]         step_x_q;
	logic [STEP_W-1:0]         step_z_q;
	logic signed [COORD_W-1:0] floor_q;
	logic [PTS_REG_W-1:0]      points_x_q;
	logic [PTS_REG_W-1:0]      points_z_q;

	// clamp grid size into 2..MAX_SIDE
	function automatic logic [PTS_W-1:0] eff_pts(input logic [PTS_REG_W-1:0] p);
		logic [CMP_W-1:0] pe;
		pe = CMP_W'(p);
		if (pe < CMP_W'(2)) begin
			return PTS_W'(2);
		end else if (pe > CMP_W'(MAX_SIDE)) begin
			return PTS_W'(MAX_SIDE);
		end else begin
			return PTS_W'(pe);
		end
	endfunction

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
			step_x_q   <= STEP_W'(65536);
			step_z_q   <= STEP_W'(65536);
			floor_q    <= '0;
			points_x_q <= PTS_REG_W'(128);
			points_z_q <= PTS_REG_W'(128);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_wdata;
				REG_ORIGIN_Z: origin_z_q <= cfg_wdata;
				REG_STEP_X:   step_x_q   <= cfg_wdata[STEP_W-1:0];
				REG_STEP_Z:   step_z_q   <= cfg_wdata[STEP_W-1:0];
				REG_FLOOR:    floor_q    <= cfg_wdata;
				REG_POINTS_X: points_x_q <= cfg_wdata[PTS_REG_W-1:0];
				REG_POINTS_Z: points_z_q <= cfg_wdata[PTS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// zero step behaves as one
	always_comb begin
		cfg.origin_x     = origin_x_q;
		cfg.origin_z     = origin_z_q;
		cfg.step_x       = (step_x_q == '0) ? STEP_W'(1) : step_x_q;
		cfg.step_z       = (step_z_q == '0) ? STEP_W'(1) : step_z_q;
		cfg.floor_height = floor_q;
	end

	assign pts_x = eff_pts(points_x_q);
	assign pts_z = eff_pts(points_z_q);

endmodule

`default_nettype wire

@@ rtl/hmb_div.sv @@
// ---------------------------------------------------------------------------
// hmb_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmb_div import hmb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;
	logic [DIV_W-1:0] diff;

	// compare and subtract against the shifted divisor
	assign ge   = (rem_q >= dsh_q);
	assign diff = rem_q - dsh_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder, divisor and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_W'(num);
			dsh_q <= {den, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

@@ rtl/hmb_grid.sv @@
// ---------------------------------------------------------------------------
// hmb_grid
// Height grid memory, one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmb_grid import hmb_pkg::*; #(
	parameter int DEPTH  = DEF_MAX_SIDE * DEF_MAX_SIDE,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [COORD_W-1:0] wdata,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [COORD_W-1:0] rdata
);

	logic [COORD_W-1:0] mem [DEPTH];
	logic [COORD_W-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/heightfield_max_binning.sv @@
// ---------------------------------------------------------------------------
// heightfield_max_binning
// Max-height grid binning of Q16.16 vertices with clear and cell read.
// ---------------------------------------------------------------------------
// Usage: drive cmd and pulse start while busy is low; the word is taken at
// that edge. kind clear loads every grid cell with floor_height, kind vertex
// bins pos_x/pos_z into a cell and raises it to pos_y, kind read returns a
// cell. Kind 3 is taken and dropped without a result.
// Each result word appears on res for one cycle with done high; the
// receiver cannot stall, so it must take it then.
// Steps, from the accept edge to the cycle done is high:
//   vertex: two passes of the shared 9-step divider (x then z), then
//           one read-modify-write of the grid memory
//   read:   one registered memory read
//   clear:  all MAX_SIDE*MAX_SIDE cells written, one cell per cycle
// busy drops in the cycle done is shown, so a next word can be taken then.
// Reset: registers take their reset values and a clearing pass writes zero
// to all MAX_SIDE*MAX_SIDE cells with busy high; configuration writes are
// taken at any time through cfg_we.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heightfield_max_binning import hmb_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  hmb_in_t              cmd,
	output logic                 busy,
	output logic                 done,
	output hmb_out_t             res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata
);

	localparam int IDX_W  = $clog2(MAX_SIDE);
	localparam int PTS_W  = IDX_W + 1;
	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);

	hmb_cfg_t             cfg;
	logic [PTS_W-1:0]     pts_x;
	logic [PTS_W-1:0]     pts_z;

	hmb_state_t           state_q;
	hmb_state_t           state_d;
	hmb_in_t              item_q;
	logic [LAND_W-1:0]    col_q;
	logic [LAND_W-1:0]    row_q;
	logic                 oor_q;
	logic [ADDR_W-1:0]    sweep_q;
	logic                 sweep_last;
	logic                 accept;

	logic                 div_start;
	logic                 div_busy;
	logic                 div_done;
	logic [NUM_W-1:0]     div_num;
	logic [DEN_W-1:0]     div_den;
	logic [QUO_W-1:0]     div_quo;

	logic [PTS_W-1:0]     pts_m1;
	logic [LAND_W-1:0]    idx_clamp;

	logic                 grid_we;
	logic [ADDR_W-1:0]    grid_waddr;
	logic [COORD_W-1:0]   grid_wdata;
	logic [ADDR_W-1:0]    cell_addr;
	logic [COORD_W-1:0]   grid_rdata;
	logic                 y_gt;

	logic                 done_q;
	hmb_out_t             res_q;

	// numerator 4*(pos-origin)+step, zero when the offset is negative
	function automatic logic [NUM_W-1:0] axis_num(
		input logic signed [COORD_W-1:0] pos,
		input logic signed [COORD_W-1:0] org,
		input logic [STEP_W-1:0]         stp
	);
		logic [COORD_W:0] d;
		d = {pos[COORD_W-1], pos} - {org[COORD_W-1], org};
		if (d[COORD_W]) begin
			return '0;
		end else begin
			return {1'b0, d[COORD_W-1:0], 2'b00} + {4'b0000, stp};
		end
	endfunction

	hmb_cfg #(
		.MAX_SIDE(MAX_SIDE)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg),
		.pts_x    (pts_x),
		.pts_z    (pts_z)
	);

	hmb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	hmb_grid #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_grid (
		.clk  (clk),
		.we   (grid_we),
		.waddr(grid_waddr),
		.wdata(grid_wdata),
		.raddr(cell_addr),
		.rdata(grid_rdata)
	);

	assign accept     = start && (state_q == ST_IDLE);
	assign sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));
	assign cell_addr  = ADDR_W'(row_q) * ADDR_W'(MAX_SIDE) + ADDR_W'(col_q);
	assign y_gt       = (item_q.pos_y > $signed(grid_rdata));

	// divider operands for the axis being worked on
	always_comb begin
		if (state_q == ST_ZGO) begin
			div_num = axis_num(item_q.pos_z, cfg.origin_z, cfg.step_z);
			div_den = {cfg.step_z, 2'b00};
		end else begin
			div_num = axis_num(item_q.pos_x, cfg.origin_x, cfg.step_x);
			div_den = {cfg.step_x, 2'b00};
		end
	end

	// saturate the quotient at points minus one
	always_comb begin
		pts_m1 = (state_q == ST_ZRUN) ? (pts_z - PTS_W'(1)) : (pts_x - PTS_W'(1));
		if (CMP_W'(div_quo) > CMP_W'(pts_m1)) begin
			idx_clamp = LAND_W'(pts_m1);
		end else begin
			idx_clamp = LAND_W'(div_quo);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd.kind)
						KIND_CLEAR:  state_d = ST_CLEAR;
						KIND_VERTEX: state_d = ST_XGO;
						KIND_READ:   state_d = ST_RD;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_XGO: state_d = ST_XRUN;
			ST_XRUN: begin
				if (div_done) begin
					state_d = ST_ZGO;
				end
			end
			ST_ZGO: state_d = ST_ZRUN;
			ST_ZRUN: begin
				if (div_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD:   state_d = ST_UPD;
			ST_UPD:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		busy       = (state_q != ST_IDLE);
		div_start  = (state_q == ST_XGO) || (state_q == ST_ZGO);
		grid_we    = 1'b0;
		grid_waddr = cell_addr;
		grid_wdata = item_q.pos_y;
		case (state_q)
			ST_INIT: begin
				grid_we    = 1'b1;
				grid_waddr = sweep_q;
				grid_wdata = '0;
			end
			ST_CLEAR: begin
				grid_we    = 1'b1;
				grid_waddr = sweep_q;
				grid_wdata = cfg.floor_height;
			end
			ST_UPD: begin
				grid_we = (item_q.kind == KIND_VERTEX) && y_gt;
			end
			default: ;
		endcase
	end

	// state and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_INIT) || (state_q == ST_CLEAR)) begin
				sweep_q <= sweep_last ? '0 : (sweep_q + ADDR_W'(1));
			end
			done_q <= (state_q == ST_UPD) || ((state_q == ST_CLEAR) && sweep_last);
		end
	end

	// item word, cell indexes and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
			col_q  <= LAND_W'(cmd.cell_col);
			row_q  <= LAND_W'(cmd.cell_row);
			oor_q  <= (CMP_W'(cmd.cell_col) >= CMP_W'(pts_x)) ||
			          (CMP_W'(cmd.cell_row) >= CMP_W'(pts_z));
		end
		if ((state_q == ST_XRUN) && div_done) begin
			col_q <= idx_clamp;
		end
		if ((state_q == ST_ZRUN) && div_done) begin
			row_q <= idx_clamp;
		end
		if (state_q == ST_UPD) begin
			res_q.landed_col <= CELL_W'(col_q);
			res_q.landed_row <= CELL_W'(row_q);
			if (item_q.kind == KIND_VERTEX) begin
				res_q.height <= y_gt ? item_q.pos_y : $signed(grid_rdata);
				res_q.status <= 1'b0;
			end else if (oor_q) begin
				res_q.height <= '0;
				res_q.status <= 1'b1;
			end else begin
				res_q.height <= $signed(grid_rdata);
				res_q.status <= 1'b0;
			end
		end else if (state_q == ST_CLEAR) begin
			res_q <= '0;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	// checks
	`include "heightfield_max_binning_macros.svh"

	`HMB_ASSERT_SAME(a_div_free, div_start, !div_busy, "divider restarted while running")
	`HMB_ASSERT_NEXT(a_done_src, (state_q == ST_UPD) || ((state_q == ST_CLEAR) && sweep_last), done, "result word missing")
	`HMB_ASSERT_NEXT(a_busy_take, start && !busy && (cmd.kind != KIND_NONE), busy, "accepted word did not raise busy")
	`HMB_ASSERT_SAME(a_oor_zero, done && res.status, res.height == '0, "out of range read with nonzero height")

endmodule

`default_nettype wire
